// ===== hw/rtl/wtm_pkg.sv =====
// ----------------------------------------------------------------------------
// wtm_pkg
// Shared types and constants for the windowed trimmed-mean filter.
// ----------------------------------------------------------------------------
package wtm_pkg;

  // Item field widths
  localparam int REGION_W   = 4;
  localparam int VALUE_BITS = 16;
  localparam int NLANE      = 4;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 72;
  localparam int DC_W       = $clog2(VALUE_BITS);

  // Configuration registers
  localparam int FILTER_MODE_W  = 2;
  localparam int WINDOW_COUNT_W = 4;
  localparam int REGION_COUNT_W = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT = 2'd2;

  localparam logic [FILTER_MODE_W-1:0]  FILTER_MODE_RST  = 2'd0;
  localparam logic [WINDOW_COUNT_W-1:0] WINDOW_COUNT_RST = 4'd8;
  localparam logic [REGION_COUNT_W-1:0] REGION_COUNT_RST = 5'd16;

  localparam logic [FILTER_MODE_W-1:0] MODE_LATEST = 2'd0;

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef value_t [NLANE-1:0]    quad_t;

  // How the merge stage builds a result
  typedef enum logic [1:0] {
    SEL_PASS,   // latest values of the item
    SEL_ZERO,   // region outside the frame
    SEL_ERR,    // trimmed mean over too few slots
    SEL_DIV     // lane quotients
  } sel_t;

  // Sequencer to lane control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
    logic acc;
    logic live;
    logic trim;
    logic div_start;
    logic div_step;
  } lane_ctrl_t;

endpackage

// ===== hw/rtl/wtm_lane.sv =====
// ----------------------------------------------------------------------------
// wtm_lane
// One value lane: ring storage, sum/min/max walk and restoring divider.
// ----------------------------------------------------------------------------
module wtm_lane import wtm_pkg::*; #(
  parameter int DEPTH = 128,
  parameter int AD_W  = 7,
  parameter int WC_W  = 4
) (
  input  logic             clk,
  input  lane_ctrl_t       ctrl,
  input  logic [AD_W-1:0]  wr_addr,
  input  value_t           wr_data,
  input  logic [AD_W-1:0]  rd_addr,
  input  logic [WC_W-1:0]  divisor,
  output value_t           quotient
);

  localparam int SUM_W = VALUE_BITS + WC_W;

  value_t             mem [DEPTH];
  value_t             rd_data;
  logic [SUM_W-1:0]   sum;
  value_t             mn;
  value_t             mx;
  logic [SUM_W-1:0]   rem;
  value_t             shq;

  value_t             v;
  logic [SUM_W-1:0]   num;
  logic [SUM_W:0]     trial;
  logic               ge;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // slots never written since the last clear read as zero
  assign v   = ctrl.live ? rd_data : '0;
  assign num = ctrl.trim ? (sum - SUM_W'(mn) - SUM_W'(mx)) : sum;

  assign trial = {rem, shq[VALUE_BITS-1]};
  assign ge    = (trial >= (SUM_W+1)'(divisor));

  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      sum <= '0;
      mn  <= '1;
      mx  <= '0;
    end else if (ctrl.acc) begin
      sum <= sum + SUM_W'(v);
      if (v < mn) mn <= v;
      if (v > mx) mx <= v;
    end

    // quotient fits VALUE_BITS, so the top bits of num start as remainder
    if (ctrl.div_start) begin
      rem <= num >> VALUE_BITS;
      shq <= num[VALUE_BITS-1:0];
    end else if (ctrl.div_step) begin
      rem <= ge ? SUM_W'(trial - (SUM_W+1)'(divisor)) : SUM_W'(trial);
      shq <= {shq[VALUE_BITS-2:0], ge};
    end
  end

  assign quotient = shq;

endmodule

// ===== hw/rtl/wtm_merge.sv =====
// ----------------------------------------------------------------------------
// wtm_merge
// Combines the lane results into one result item and holds it for output.
// ----------------------------------------------------------------------------
module wtm_merge import wtm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  sel_t                  sel,
  input  logic [REGION_W-1:0]   region,
  input  quad_t                 latest,
  input  quad_t                 quot,
  output logic                  can_load,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]            m_tuser
);

  quad_t vals;
  logic  err;

  always_comb begin
    unique case (sel)
      SEL_PASS: begin
        vals = latest;
        err  = 1'b0;
      end
      SEL_ZERO: begin
        vals = '0;
        err  = 1'b0;
      end
      SEL_ERR: begin
        vals = '0;
        err  = 1'b1;
      end
      SEL_DIV: begin
        vals = quot;
        err  = 1'b0;
      end
      default: begin
        vals = '0;
        err  = 1'b0;
      end
    endcase
  end

  assign can_load = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= OUT_DATA_W'({vals, region});
      m_tuser <= err;
    end
  end

endmodule

// ===== hw/rtl/windowed_trimmed_mean_filter.sv =====
// ----------------------------------------------------------------------------
// windowed_trimmed_mean_filter
// Per-region moving window filter: latest, average or trimmed mean.
// ----------------------------------------------------------------------------
// Each item carries four Q2.14 values for one region. The item is stored in
// the region's ring slot at the shared slot pointer, the pointer steps on
// tlast, and one result item follows for the same region. Four lanes, one
// per value, walk the region's slots 0..win_eff-1 one slot a cycle and
// then run a restoring divider one quotient bit a cycle; the merge stage
// packs the lane results into the output register. Averaging modes step
// through walk, drain, divider load, 16 divider steps, output load, idle;
// latest-value mode, regions outside the frame and the too-short-window
// error go from idle straight to output load. The walk over the ring
// memory read port and the bit-serial divider set the rate. The next item
// is taken while a result still waits at the output. Slot contents are
// tracked by one live bit per slot, cleared at reset and when window_count
// or region_count is written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_trimmed_mean_filter import wtm_pkg::*; #(
  parameter int REGION_MAX = 16,
  parameter int WINDOW_MAX = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // s_tdata: region_index[3:0], freq_value[19:4], nyquist_value[35:20],
  //          sfr_high[51:36], sfr_low[67:52], zero pad[71:68]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  // m_tdata: out_region[3:0], out_freq[19:4], out_nyquist[35:20],
  //          out_sfr_high[51:36], out_sfr_low[67:52], zero pad[71:68]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: count_error[0]
  output logic [0:0]            m_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = REGION_MAX * WINDOW_MAX;
  localparam int AD_W  = $clog2(DEPTH);
  localparam int SA_W  = $clog2(WINDOW_MAX);
  localparam int WC_W  = $clog2(WINDOW_MAX + 1);
  localparam int RCE_W = $clog2(REGION_MAX + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // configuration
  logic [FILTER_MODE_W-1:0]  filter_mode;
  logic [WINDOW_COUNT_W-1:0] window_count;
  logic [REGION_COUNT_W-1:0] region_count;

  // sequencer state
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic [SA_W-1:0]  slot_pointer;
  logic [DEPTH-1:0] live;
  logic [SA_W-1:0]  scan_idx;
  logic [DC_W-1:0]  div_cnt;
  logic             rd_pend;
  logic             live_q;

  // captured item
  logic [REGION_W-1:0] region_q;
  quad_t               val_q;
  sel_t                sel_q;
  logic                trim_q;
  logic [WC_W-1:0]     div_q;
  logic [AD_W-1:0]     base_q;

  // decode of the incoming item
  logic [REGION_W-1:0] in_region;
  quad_t               in_vals;
  logic [WC_W-1:0]     win_eff;
  logic [RCE_W-1:0]    rc_eff;
  logic                accept;
  logic                in_valid;
  logic                in_trim;
  logic [SA_W-1:0]     ptr_use;
  logic [WC_W-1:0]     ptr_inc;
  logic [AD_W-1:0]     wr_addr;
  logic [AD_W-1:0]     rd_addr;
  sel_t                in_sel;
  logic                scan_last;
  logic                can_load;
  lane_ctrl_t          ctrl;
  quad_t               quot;

  assign in_region = s_tdata[REGION_W-1:0];
  assign in_vals   = s_tdata[REGION_W +: NLANE*VALUE_BITS];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // zero acts as one, anything above the storage acts as the storage size
  always_comb begin
    if (window_count == '0) begin
      win_eff = WC_W'(1);
    end else if (32'(window_count) > WINDOW_MAX) begin
      win_eff = WC_W'(WINDOW_MAX);
    end else begin
      win_eff = WC_W'(window_count);
    end
    if (region_count == '0) begin
      rc_eff = RCE_W'(1);
    end else if (32'(region_count) > REGION_MAX) begin
      rc_eff = RCE_W'(REGION_MAX);
    end else begin
      rc_eff = RCE_W'(region_count);
    end
  end

  assign in_valid = 32'(in_region) < 32'(rc_eff);
  assign in_trim  = filter_mode[1];

  // a pointer left outside the window restarts at slot zero
  assign ptr_use = (32'(slot_pointer) >= 32'(win_eff)) ? '0 : slot_pointer;
  assign ptr_inc = WC_W'(ptr_use) + WC_W'(1);

  assign wr_addr = AD_W'(32'(in_region) * WINDOW_MAX + 32'(ptr_use));
  assign rd_addr = AD_W'(32'(base_q) + 32'(scan_idx));

  always_comb begin
    priority if (!in_valid) begin
      in_sel = SEL_ZERO;
    end else if (filter_mode == MODE_LATEST) begin
      in_sel = SEL_PASS;
    end else if (in_trim && (win_eff <= WC_W'(2))) begin
      in_sel = SEL_ERR;
    end else begin
      in_sel = SEL_DIV;
    end
  end

  assign scan_last = (32'(scan_idx) == 32'(win_eff) - 32'd1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = (in_sel == SEL_DIV) ? S_SCAN : S_DONE;
      S_SCAN:  if (scan_last) state_next = S_DRAIN;
      S_DRAIN: state_next = S_LOAD;
      S_LOAD:  state_next = S_DIV;
      S_DIV:   if (div_cnt == DC_W'(VALUE_BITS - 1)) state_next = S_DONE;
      S_DONE:  if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      slot_pointer <= '0;
      live         <= '0;
      rd_pend      <= 1'b0;
      filter_mode  <= FILTER_MODE_RST;
      window_count <= WINDOW_COUNT_RST;
      region_count <= REGION_COUNT_RST;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_SCAN);
      if (accept) begin
        if (in_valid) live[wr_addr] <= 1'b1;
        if (s_tlast) begin
          slot_pointer <= (ptr_inc >= win_eff) ? '0 : SA_W'(ptr_inc);
        end else begin
          slot_pointer <= ptr_use;
        end
      end
      // reconfiguring the window or the frame empties the rings
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FILTER_MODE: filter_mode <= cfg_data[FILTER_MODE_W-1:0];
          REG_WINDOW_COUNT: begin
            window_count <= cfg_data[WINDOW_COUNT_W-1:0];
            live         <= '0;
            slot_pointer <= '0;
          end
          REG_REGION_COUNT: begin
            region_count <= cfg_data[REGION_COUNT_W-1:0];
            live         <= '0;
            slot_pointer <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      region_q <= in_region;
      val_q    <= in_vals;
      sel_q    <= in_sel;
      trim_q   <= in_trim;
      div_q    <= in_trim ? (win_eff - WC_W'(2)) : win_eff;
      base_q   <= AD_W'(32'(in_region) * WINDOW_MAX);
      scan_idx <= '0;
    end else if (state == S_SCAN) begin
      scan_idx <= scan_idx + SA_W'(1);
    end
    if (state == S_SCAN) live_q <= live[rd_addr];
    if (state == S_LOAD) begin
      div_cnt <= '0;
    end else if (state == S_DIV) begin
      div_cnt <= div_cnt + DC_W'(1);
    end
  end

  always_comb begin
    ctrl           = '0;
    ctrl.wr_en     = accept && in_valid;
    ctrl.clr       = accept;
    ctrl.rd_en     = (state == S_SCAN);
    ctrl.acc       = rd_pend;
    ctrl.live      = live_q;
    ctrl.trim      = trim_q;
    ctrl.div_start = (state == S_LOAD);
    ctrl.div_step  = (state == S_DIV);
  end

  for (genvar g = 0; g < NLANE; g++) begin : g_lane
    wtm_lane #(
      .DEPTH (DEPTH),
      .AD_W  (AD_W),
      .WC_W  (WC_W)
    ) u_lane (
      .clk      (clk),
      .ctrl     (ctrl),
      .wr_addr  (wr_addr),
      .wr_data  (in_vals[g]),
      .rd_addr  (rd_addr),
      .divisor  (div_q),
      .quotient (quot[g])
    );
  end

  wtm_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     ((state == S_DONE) && can_load),
    .sel      (sel_q),
    .region   (region_q),
    .latest   (val_q),
    .quot     (quot),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hw/rtl/wtm_checker.sv =====
// ----------------------------------------------------------------------------
// wtm_checker
// Port-level checks on the windowed trimmed-mean filter.
// ----------------------------------------------------------------------------
module wtm_checker import wtm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]            m_tuser
);

  localparam int PAY_W = REGION_W + NLANE * VALUE_BITS;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an error result carries zero values
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[PAY_W-1:REGION_W] == '0)
    else $error("error result with non-zero values");

  // pad bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:PAY_W] == '0)
    else $error("output pad bits set");

  // one item at a time: input closes after an accepted item
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input open right after an accepted item");

  // no result straight out of reset
  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind windowed_trimmed_mean_filter wtm_checker u_wtm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/windowed_trimmed_mean_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_trimmed_mean_filter_tb
// Self-checking bench for the per-region moving window filter.
// ----------------------------------------------------------------------------
// Items go in on the slave stream. A behavioural copy of the ring store
// predicts each filtered result, and every result item on the master stream
// is checked against the oldest prediction. Directed tests cover the three
// modes, the error case and the range limits of the registers. An output
// hold-off fills the block. Random frames, noise and broken frames follow
// under many register settings. Both streams idle at random.
// ----------------------------------------------------------------------------
module windowed_trimmed_mean_filter_tb;
  import wtm_pkg::*;

  localparam int REGIONS      = 16;
  localparam int SLOTS        = 8;
  localparam int HOLD_CYCLES  = 300;   // long output hold-off
  localparam int SETTLE       = 30;    // quiet time after the last result comes out
  localparam int WATCHDOG_MAX = 4000;  // cycles with no item moving
  localparam int RANDOM_ITEMS = 390;

  // filter_mode codes beyond the package's latest-value code
  localparam logic [FILTER_MODE_W-1:0] MODE_AVERAGE     = 2'd1;
  localparam logic [FILTER_MODE_W-1:0] MODE_TRIMMED     = 2'd2;
  localparam logic [FILTER_MODE_W-1:0] MODE_TRIMMED_ALT = 2'd3;
  // unmapped register index, writes are dropped
  localparam logic [CFG_IDX_W-1:0]     REG_UNUSED       = 2'd3;

  typedef struct {
    logic [REGION_W-1:0] region;
    quad_t               vals;   // lane 0 freq, 1 nyquist, 2 sfr_high, 3 sfr_low
    logic                last;
  } meas_item_t;

  typedef struct {
    logic [REGION_W-1:0] region;
    quad_t               vals;
    logic                err;
  } filtered_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // region_index, freq, nyquist, sfr_high, sfr_low, pad
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;   // out_region, out_freq, out_nyquist, out_sfr_high,
                                    // out_sfr_low, pad
  logic [0:0]            m_tuser;   // count_error
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  windowed_trimmed_mean_filter u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the ring store, pointer and registers
  // ---------------------------------------------------------------------------
  quad_t                     ring_mem [REGIONS][SLOTS];
  int unsigned               slot_ptr;
  logic [FILTER_MODE_W-1:0]  mode_reg;
  logic [WINDOW_COUNT_W-1:0] window_reg;
  logic [REGION_COUNT_W-1:0] regions_reg;

  filtered_t   pending_results [$];
  int          err_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned cfg_writes;
  int unsigned phases_run;
  bit          hold_request;   // asks the receiver for one long hold-off
  bit          tx_calm;        // no sender gaps
  bit          rx_calm;        // no receiver stalls

  string lane_name [NLANE] = '{"out_freq", "out_nyquist", "out_sfr_high", "out_sfr_low"};

  function automatic int unsigned active_window();
    if (window_reg == 0)     return 1;
    if (window_reg > SLOTS)  return SLOTS;
    return window_reg;
  endfunction

  function automatic int unsigned active_regions();
    if (regions_reg == 0)      return 1;
    if (regions_reg > REGIONS) return REGIONS;
    return regions_reg;
  endfunction

  task automatic clear_ring();
    for (int r = 0; r < REGIONS; r++)
      for (int s = 0; s < SLOTS; s++)
        ring_mem[r][s] = '0;
    slot_ptr = 0;
  endtask

  task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_FILTER_MODE:  mode_reg = data[FILTER_MODE_W-1:0];
      REG_WINDOW_COUNT: begin
        window_reg = data[WINDOW_COUNT_W-1:0];
        clear_ring();
      end
      REG_REGION_COUNT: begin
        regions_reg = data[REGION_COUNT_W-1:0];
        clear_ring();
      end
      default: ;
    endcase
  endtask

  // Store the item, step the pointer, then filter over the region's window
  task automatic compute_filtered(input meas_item_t it, output filtered_t res);
    int unsigned win;
    logic        stored;
    logic [19:0] sum;
    value_t      mn;
    value_t      mx;
    value_t      v;
    win    = active_window();
    stored = (it.region < active_regions());
    if (slot_ptr >= win) slot_ptr = 0;
    if (stored) ring_mem[it.region][slot_ptr] = it.vals;
    if (it.last) begin
      slot_ptr++;
      if (slot_ptr >= win) slot_ptr = 0;
    end
    res.region = it.region;
    res.vals   = '0;
    res.err    = 1'b0;
    if (stored) begin
      case (mode_reg)
        MODE_LATEST: res.vals = it.vals;
        MODE_AVERAGE: begin
          for (int k = 0; k < NLANE; k++) begin
            sum = '0;
            for (int s = 0; s < win; s++) sum += ring_mem[it.region][s][k];
            res.vals[k] = value_t'(sum / win);
          end
        end
        default: begin
          // trimmed mean, mode three behaves the same
          if (win <= 2) begin
            res.err = 1'b1;
          end else begin
            for (int k = 0; k < NLANE; k++) begin
              sum = '0;
              mn  = '1;
              mx  = '0;
              for (int s = 0; s < win; s++) begin
                v = ring_mem[it.region][s][k];
                sum += v;
                if (v < mn) mn = v;
                if (v > mx) mx = v;
              end
              sum = sum - mn - mx;
              res.vals[k] = value_t'(sum / (win - 2));
            end
          end
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic value_t rand_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return value_t'($urandom);
  endfunction

  function automatic meas_item_t make_item(input int unsigned region, input value_t f,
                                           input value_t n, input value_t h,
                                           input value_t l, input bit last);
    meas_item_t it;
    it.region  = region[REGION_W-1:0];
    it.vals[0] = f;
    it.vals[1] = n;
    it.vals[2] = h;
    it.vals[3] = l;
    it.last    = last;
    return it;
  endfunction

  function automatic meas_item_t rand_item(input int unsigned region, input bit last);
    return make_item(region, rand_value(), rand_value(), rand_value(), rand_value(), last);
  endfunction

  // Offer one item after an optional gap; predict it once it is taken
  task automatic send_item(input meas_item_t it, input int unsigned gap);
    filtered_t res;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - REGION_W - NLANE*VALUE_BITS){1'b0}}, it.vals, it.region};
    s_tlast  <= it.last;
    do @(posedge clk); while (s_tready !== 1'b1);
    compute_filtered(it, res);
    pending_results.push_back(res);
    items_sent++;
  endtask

  task automatic send_paced(input meas_item_t it);
    send_item(it, tx_calm ? 0 : pick_gap());
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    apply_config(idx, data);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, one long hold-off on request, checking
  // ---------------------------------------------------------------------------
  task automatic check_result();
    filtered_t           exp;
    logic [REGION_W-1:0] got_region;
    quad_t               got_vals;
    results_seen++;
    got_region = m_tdata[REGION_W-1:0];
    got_vals   = m_tdata[REGION_W +: NLANE*VALUE_BITS];
    if (pending_results.size() == 0) begin
      $error("unexpected result item: out_region %0d", got_region);
      err_cnt++;
    end else begin
      exp = pending_results.pop_front();
      if (got_region !== exp.region) begin
        $error("out_region: expected %0d, actual %0d", exp.region, got_region);
        err_cnt++;
      end
      for (int k = 0; k < NLANE; k++)
        if (got_vals[k] !== exp.vals[k]) begin
          $error("%s: expected 0x%04h, actual 0x%04h", lane_name[k], exp.vals[k],
                 got_vals[k]);
          err_cnt++;
        end
      if (m_tuser[0] !== exp.err) begin
        $error("count_error: expected %0b, actual %0b", exp.err, m_tuser[0]);
        err_cnt++;
      end
    end
  endtask

  initial begin : result_side
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && m_tvalid === 1'b1 && m_tready === 1'b1) check_result();
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end
      if (stall_left == 0 && !rx_calm && $urandom_range(0, 99) < 20)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no item moves on either side for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid === 1'b1 && s_tready === 1'b1) ||
          (m_tvalid === 1'b1 && m_tready === 1'b1))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_MAX) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset settings: latest values pass through, extremes of every field
  task automatic test_passthrough();
    send_paced(make_item(0, '0, '0, '0, '0, 1'b0));
    send_paced(make_item(15, '1, '1, '1, '1, 1'b0));
    send_paced(rand_item(7, 1'b1));
    send_paced(make_item(8, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000, 1'b1));
  endtask

  // Window average over three slots, two regions; wraps the pointer
  task automatic test_window_average();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_AVERAGE));
    write_reg(REG_WINDOW_COUNT, 5'd3);
    write_reg(REG_REGION_COUNT, 5'd2);
    for (int f = 0; f < 4; f++) begin
      send_paced(make_item(0, '1, '1, '1, '1, 1'b0));
      send_paced(rand_item(1, 1'b1));
    end
  endtask

  // Trimmed mean, then mode three on the same store
  task automatic test_trimmed_mean();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_TRIMMED));
    write_reg(REG_WINDOW_COUNT, 5'd4);
    write_reg(REG_REGION_COUNT, 5'd1);
    send_paced(make_item(0, '1, '0, 16'h4000, '1, 1'b1));
    for (int i = 0; i < 4; i++) send_paced(rand_item(0, 1'b1));
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_TRIMMED_ALT));
    send_paced(rand_item(0, 1'b1));
    send_paced(make_item(0, '0, '1, '0, '1, 1'b0));
  endtask

  // Too few slots for the trimmed mean: zeros and the error flag
  task automatic test_count_error();
    write_reg(REG_WINDOW_COUNT, 5'd2);
    send_paced(rand_item(0, 1'b1));
    send_paced(rand_item(0, 1'b0));
    write_reg(REG_WINDOW_COUNT, 5'd0);
    send_paced(rand_item(0, 1'b1));
  endtask

  // Window and region counts beyond range, regions outside the frame
  task automatic test_range_limits();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_AVERAGE));
    write_reg(REG_WINDOW_COUNT, 5'd15);
    write_reg(REG_REGION_COUNT, 5'd31);
    send_paced(make_item(15, '1, '1, '1, '1, 1'b1));
    send_paced(rand_item(3, 1'b0));
    write_reg(REG_REGION_COUNT, 5'd0);
    write_reg(REG_UNUSED, 5'h1F);
    send_paced(rand_item(0, 1'b0));
    send_paced(rand_item(9, 1'b1));
  endtask

  // Receiver holds off while the sender keeps offering back to back
  task automatic test_output_backpressure();
    write_reg(REG_FILTER_MODE, CFG_DATA_W'(MODE_TRIMMED));
    write_reg(REG_WINDOW_COUNT, 5'd8);
    write_reg(REG_REGION_COUNT, 5'd16);
    hold_request = 1'b1;
    for (int i = 0; i < 12; i++) send_item(rand_item(i, i == 11), 0);
    drain_results();
  endtask

  // Random settings, mostly well-formed frames with random content,
  // plus noise items and broken frames
  task automatic test_random_frames();
    int unsigned            sent_here;
    int unsigned            frames;
    int unsigned            nreg;
    int unsigned            len;
    logic [CFG_DATA_W-1:0]  win_raw;
    logic [CFG_DATA_W-1:0]  reg_raw;
    logic [CFG_DATA_W-1:0]  win_edge [6];
    logic [CFG_DATA_W-1:0]  reg_edge [5];
    win_edge  = '{5'd0, 5'd1, 5'd2, 5'd8, 5'd15, 5'd19};
    reg_edge  = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd17};
    sent_here = 0;
    while (sent_here < RANDOM_ITEMS) begin
      phases_run++;
      if ($urandom_range(0, 2) == 0) win_raw = win_edge[$urandom_range(0, 5)];
      else                           win_raw = CFG_DATA_W'($urandom_range(1, 8));
      if ($urandom_range(0, 3) == 0) reg_raw = reg_edge[$urandom_range(0, 4)];
      else                           reg_raw = CFG_DATA_W'($urandom_range(1, 6));
      write_reg(REG_FILTER_MODE, CFG_DATA_W'($urandom_range(0, 3)));
      write_reg(REG_WINDOW_COUNT, win_raw);
      write_reg(REG_REGION_COUNT, reg_raw);
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      nreg    = active_regions();
      frames  = $urandom_range(3, 10);
      for (int f = 0; f < frames; f++) begin
        if ($urandom_range(0, 99) < 80) begin
          for (int r = 0; r < nreg; r++) send_paced(rand_item(r, r == nreg - 1));
          sent_here += nreg;
        end else begin
          // noise: any region, stray frame marks
          len = $urandom_range(1, nreg + 2);
          for (int i = 0; i < len; i++)
            send_paced(rand_item($urandom_range(0, 15), $urandom_range(0, 3) == 0));
          sent_here += len;
        end
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tlast      = 1'b0;
    m_tready     = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    err_cnt      = 0;
    items_sent   = 0;
    results_seen = 0;
    cfg_writes   = 0;
    phases_run   = 0;
    hold_request = 1'b0;
    tx_calm      = 1'b0;
    rx_calm      = 1'b0;
    mode_reg     = FILTER_MODE_RST;
    window_reg   = WINDOW_COUNT_RST;
    regions_reg  = REGION_COUNT_RST;
    clear_ring();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    test_passthrough();
    test_window_average();
    test_trimmed_mean();
    test_count_error();
    test_range_limits();
    test_output_backpressure();
    test_random_frames();

    drain_results();
    $display("Run covered %0d items, %0d results, %0d register writes, %0d random phases",
             items_sent, results_seen, cfg_writes, phases_run);
    $display("Modes latest, average and trimmed, window and region limits, long hold-off");
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
